/* rtl/bkvl_pkg.sv */
`default_nettype none
package bkvl_pkg;

  // text length limit and the resulting position cap
  localparam longint unsigned MAX_TEXT_LEN = 64'd16777216;
  localparam int              POS_W        = 24;
  localparam longint unsigned FIELD_MAX    = (64'd1 << POS_W) - 64'd1;
  localparam longint unsigned CAP_RAW      = (MAX_TEXT_LEN == 64'd0) ? 64'd0 :
                                             (MAX_TEXT_LEN - 64'd1);
  localparam logic [POS_W-1:0] POS_CAP     = (CAP_RAW > FIELD_MAX) ?
                                             POS_W'(FIELD_MAX) : POS_W'(CAP_RAW);
  localparam logic [POS_W-1:0] LEN_MAX     = POS_W'(FIELD_MAX);

  // byte codes
  localparam logic [7:0] CH_QUOTE     = 8'd34;
  localparam logic [7:0] CH_BACKSLASH = 8'd92;
  localparam logic [7:0] CH_EQUALS    = 8'd61;
  localparam logic [7:0] CH_LBRACE    = 8'd123;
  localparam logic [7:0] CH_RBRACE    = 8'd125;
  localparam logic [7:0] CH_UPPER_A   = 8'd65;
  localparam logic [7:0] CH_UPPER_Z   = 8'd90;
  localparam logic [7:0] CH_LOWER_A   = 8'd97;
  localparam logic [7:0] CH_LOWER_Z   = 8'd122;
  localparam logic [7:0] CH_DIGIT_0   = 8'd48;
  localparam logic [7:0] CH_DIGIT_9   = 8'd57;
  localparam logic [7:0] CH_DOT       = 8'd46;
  localparam logic [7:0] CH_UNDERSCORE = 8'd95;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // everything one byte produces: up to two tokens and a summary
  typedef struct packed {
    logic             tok0_vld;
    logic [POS_W-1:0] tok0_start;
    logic [POS_W-1:0] tok0_len;
    logic             tok1_vld;
    logic [POS_W-1:0] tok1_start;
    logic             summ_vld;
    logic             found_any;
    logic             overflowed;
  } rec_t;

  function automatic logic is_name_byte(input logic [7:0] c);
    is_name_byte = ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
                   ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
                   ((c >= CH_DIGIT_0) && (c <= CH_DIGIT_9)) ||
                   (c == CH_DOT) || (c == CH_UNDERSCORE);
  endfunction

endpackage
`default_nettype wire

/* rtl/bkvl_front.sv */
`default_nettype none
module bkvl_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          byte_vld,
  input  wire logic [7:0]    char_code,
  input  wire logic          end_of_text,
  input  wire logic          q_ready,
  output logic               byte_rdy,
  output logic               push,
  output bkvl_pkg::rec_t     push_rec
);

  logic                        in_string_r, in_string_nxt;
  logic [bkvl_pkg::POS_W-1:0]  open_start_r, open_start_nxt;
  logic [bkvl_pkg::POS_W-1:0]  open_len_r, open_len_nxt;
  logic [7:0]                  prior_r, prior_nxt;
  logic [bkvl_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic                        any_r, any_nxt;
  logic                        sat_r, sat_nxt;

  logic                        fire;
  logic                        at_cap;
  logic [bkvl_pkg::POS_W-1:0]  after;
  logic                        sat_now;
  logic                        tok0, tok1;
  logic                        is_punct;

  assign byte_rdy = q_ready;
  assign fire     = byte_vld && q_ready;
  assign at_cap   = (pos_r >= bkvl_pkg::POS_CAP);
  assign after    = at_cap ? bkvl_pkg::POS_CAP : (pos_r + 1'b1);
  assign sat_now  = sat_r | at_cap;
  assign is_punct = (char_code == bkvl_pkg::CH_EQUALS) ||
                    (char_code == bkvl_pkg::CH_LBRACE) ||
                    (char_code == bkvl_pkg::CH_RBRACE);

  always_comb begin
    in_string_nxt  = in_string_r;
    open_start_nxt = open_start_r;
    open_len_nxt   = open_len_r;
    tok0           = 1'b0;
    tok1           = 1'b0;
    if (in_string_r) begin
      if ((char_code == bkvl_pkg::CH_QUOTE) &&
          ((open_len_r == '0) || (prior_r != bkvl_pkg::CH_BACKSLASH))) begin
        tok0           = 1'b1;
        open_start_nxt = after;
        open_len_nxt   = '0;
        in_string_nxt  = 1'b0;
      end else if (open_len_r < bkvl_pkg::LEN_MAX) begin
        open_len_nxt = open_len_r + 1'b1;
      end
    end else begin
      if (char_code == bkvl_pkg::CH_QUOTE) begin
        in_string_nxt  = 1'b1;
        open_start_nxt = after;
        open_len_nxt   = '0;
      end else if (is_punct) begin
        tok0           = (open_len_r != '0);
        tok1           = 1'b1;
        open_start_nxt = after;
        open_len_nxt   = '0;
      end else if (!bkvl_pkg::is_name_byte(char_code)) begin
        tok0           = (open_len_r != '0);
        open_start_nxt = after;
        open_len_nxt   = '0;
      end else if (open_len_r < bkvl_pkg::LEN_MAX) begin
        open_len_nxt = open_len_r + 1'b1;
      end
    end
    any_nxt   = any_r | tok0 | tok1;
    sat_nxt   = sat_now;
    prior_nxt = char_code;
    pos_nxt   = after;
    // summary ends the text: everything back to its reset value
    if (end_of_text) begin
      in_string_nxt  = 1'b0;
      open_start_nxt = '0;
      open_len_nxt   = '0;
      prior_nxt      = '0;
      pos_nxt        = '0;
      any_nxt        = 1'b0;
      sat_nxt        = 1'b0;
    end
  end

  always_comb begin
    push                = fire && (tok0 || tok1 || end_of_text);
    push_rec.tok0_vld   = tok0;
    push_rec.tok0_start = open_start_r;
    push_rec.tok0_len   = open_len_r;
    push_rec.tok1_vld   = tok1;
    push_rec.tok1_start = pos_r;
    push_rec.summ_vld   = end_of_text;
    push_rec.found_any  = any_r | tok0 | tok1;
    push_rec.overflowed = sat_now;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_string_r  <= 1'b0;
      open_start_r <= '0;
      open_len_r   <= '0;
      prior_r      <= '0;
      pos_r        <= '0;
      any_r        <= 1'b0;
      sat_r        <= 1'b0;
    end else if (fire) begin
      in_string_r  <= in_string_nxt;
      open_start_r <= open_start_nxt;
      open_len_r   <= open_len_nxt;
      prior_r      <= prior_nxt;
      pos_r        <= pos_nxt;
      any_r        <= any_nxt;
      sat_r        <= sat_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/bkvl_queue.sv */
`default_nettype none
module bkvl_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire bkvl_pkg::rec_t push_rec,
  output logic                not_full,
  output logic                not_empty,
  input  wire logic           pop,
  output bkvl_pkg::rec_t      pop_rec
);

  bkvl_pkg::rec_t                mem_r [bkvl_pkg::QUEUE_DEPTH];
  logic [bkvl_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [bkvl_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [bkvl_pkg::QCNT_W-1:0]   count_r, count_nxt;
  logic                          do_push, do_pop;

  assign not_full  = (count_r != bkvl_pkg::QCNT_W'(bkvl_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign pop_rec   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == bkvl_pkg::QPTR_W'(bkvl_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : (wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == bkvl_pkg::QPTR_W'(bkvl_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : (rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule
`default_nettype wire

/* rtl/bkvl_back.sv */
`default_nettype none
module bkvl_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_vld,
  input  wire bkvl_pkg::rec_t              q_rec,
  output logic                             q_pop,
  output logic                             res_vld,
  input  wire logic                        res_rdy,
  output logic [bkvl_pkg::POS_W-1:0]       token_start,
  output logic [bkvl_pkg::POS_W-1:0]       token_length,
  output logic                             is_summary,
  output logic                             found_any,
  output logic                             overflowed,
  output logic                             last_of_run
);

  bkvl_pkg::rec_t rec_r;
  // pending results: bit 0 first token, bit 1 punctuation token, bit 2 summary
  logic [2:0]     pend_r, pend_nxt;
  logic [2:0]     pend_after;
  logic           fire;
  logic           can_load;

  always_comb begin
    pend_after = pend_r;
    if (pend_r[0]) begin
      pend_after[0] = 1'b0;
    end else if (pend_r[1]) begin
      pend_after[1] = 1'b0;
    end else begin
      pend_after[2] = 1'b0;
    end
  end

  assign res_vld  = (pend_r != 3'b000);
  assign fire     = res_vld && res_rdy;
  assign can_load = !res_vld || (fire && (pend_after == 3'b000));
  assign q_pop    = can_load && q_vld;

  always_comb begin
    token_start  = '0;
    token_length = '0;
    is_summary   = 1'b0;
    found_any    = 1'b0;
    overflowed   = 1'b0;
    if (pend_r[0]) begin
      token_start  = rec_r.tok0_start;
      token_length = rec_r.tok0_len;
    end else if (pend_r[1]) begin
      token_start  = rec_r.tok1_start;
      token_length = bkvl_pkg::POS_W'(1);
    end else begin
      is_summary   = 1'b1;
      found_any    = rec_r.found_any;
      overflowed   = rec_r.overflowed;
    end
    last_of_run = (pend_after == 3'b000);
  end

  always_comb begin
    pend_nxt = pend_r;
    if (q_pop) begin
      pend_nxt = {q_rec.summ_vld, q_rec.tok1_vld, q_rec.tok0_vld};
    end else if (fire) begin
      pend_nxt = pend_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 3'b000;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rec_r <= q_rec;
    end
  end

endmodule
`default_nettype wire

/* rtl/brace_key_value_lexer.sv */
// brace key/value text lexer: one text byte per input word (tlast flags the
// final byte of a text), tokens out as start position and length, and after
// the final byte a summary word telling whether any token was seen and
// whether the 24-bit position counter saturated. a front stage classifies
// each byte and updates the lexer state, so a byte is taken every cycle
// while the four-word queue has room; the back stage sends one result word
// per cycle while out_tready is high, so a byte with k results (k up to 3)
// holds the output until all k are sent; the sustained rate is one byte per
// cycle if bytes average at most one result and out_tready stays high. a name
// or string open at end of text is dropped; all state clears after the summary
`default_nettype none
module brace_key_value_lexer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input words
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_code
  input  wire logic        in_tlast,   // end_of_text
  // result words
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [23:0] token_start, [47:24] token_length
  output logic [2:0]       out_tuser,  // [0] is_summary, [1] found_any, [2] overflowed
  output logic             out_tlast   // last_of_run
);

  logic                        q_not_full;
  logic                        q_not_empty;
  logic                        q_push;
  logic                        q_pop;
  bkvl_pkg::rec_t              push_rec;
  bkvl_pkg::rec_t              pop_rec;
  logic [bkvl_pkg::POS_W-1:0]  token_start;
  logic [bkvl_pkg::POS_W-1:0]  token_length;
  logic                        is_summary;
  logic                        found_any;
  logic                        overflowed;

  // classify and track lexer state
  bkvl_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_vld    (in_tvalid),
    .char_code   (in_tdata),
    .end_of_text (in_tlast),
    .q_ready     (q_not_full),
    .byte_rdy    (in_tready),
    .push        (q_push),
    .push_rec    (push_rec)
  );

  // decouples the front from output stalls
  bkvl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_rec  (push_rec),
    .not_full  (q_not_full),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .pop_rec   (pop_rec)
  );

  // serialise each byte's results onto the output
  bkvl_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_vld        (q_not_empty),
    .q_rec        (pop_rec),
    .q_pop        (q_pop),
    .res_vld      (out_tvalid),
    .res_rdy      (out_tready),
    .token_start  (token_start),
    .token_length (token_length),
    .is_summary   (is_summary),
    .found_any    (found_any),
    .overflowed   (overflowed),
    .last_of_run  (out_tlast)
  );

  assign out_tdata = {token_length, token_start};
  assign out_tuser = {overflowed, found_any, is_summary};

endmodule
`default_nettype wire
